@@ hdl/t2dpu_pkg.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 data-processing unit package
// Op codes, shift types, encoding masks and the flag type shared by the
// result channel interface and the execution logic.
// ----------------------------------------------------------------------------
package t2dpu_pkg;

  // NZCV: N bit 3, Z bit 2, C bit 1, V bit 0
  typedef logic [3:0] nzcv_t;

  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_BIC = 4'd1,
    OP_ORR = 4'd2,
    OP_ORN = 4'd3,
    OP_EOR = 4'd4,
    OP_ADD = 4'd8,
    OP_ADC = 4'd10,
    OP_SBC = 4'd11,
    OP_SUB = 4'd13,
    OP_RSB = 4'd14
  } op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // replicated-byte immediate patterns
  typedef enum logic [1:0] {
    REP_PLAIN = 2'd0,
    REP_ODD   = 2'd1,
    REP_EVEN  = 2'd2,
    REP_ALL   = 2'd3
  } rep_t;

  localparam logic [15:0] IMM_CLASS_MASK = 16'hfa00;
  localparam logic [15:0] IMM_CLASS_CODE = 16'hf000;
  localparam logic [15:0] REG_CLASS_MASK = 16'hfe00;
  localparam logic [15:0] REG_CLASS_CODE = 16'hea00;
  localparam logic [3:0]  REG_PC         = 4'd15;

endpackage

@@ hdl/t2dpu_in_if.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 data-processing unit instruction channel
// valid/ready channel carrying one instruction and its source operands.
// ----------------------------------------------------------------------------
interface t2dpu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_half;
  logic [15:0] second_half;
  logic [31:0] rn_value;
  logic [31:0] rm_value;
  logic        register_form;

  modport source (
    output valid, first_half, second_half, rn_value, rm_value, register_form,
    input  ready
  );
  modport sink (
    input  valid, first_half, second_half, rn_value, rm_value, register_form,
    output ready
  );
endinterface

@@ hdl/t2dpu_out_if.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 data-processing unit result channel
// valid/ready channel carrying one executed result and the flags after it.
// ----------------------------------------------------------------------------
interface t2dpu_out_if;
  logic                valid;
  logic                ready;
  logic                handled;
  logic [31:0]         result_value;
  logic [3:0]          dest_index;
  logic                write_reg;
  logic                write_pc;
  t2dpu_pkg::nzcv_t    flags_out;

  modport source (
    output valid, handled, result_value, dest_index, write_reg, write_pc, flags_out,
    input  ready
  );
  modport sink (
    input  valid, handled, result_value, dest_index, write_reg, write_pc, flags_out,
    output ready
  );
endinterface

@@ hdl/thumb2_data_processing_unit.sv @@
// ----------------------------------------------------------------------------
// Thumb-2 data-processing unit
// Executes 32-bit modified-immediate and shifted-register data-processing
// instructions and keeps the NZCV flags.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: instruction halfwords, Rn/Rm values and the encoding form. A
//        transfer happens when valid and ready are both high.
//   res: one result per instruction: handled, value, Rd, write enables and
//        the flags after the instruction, in instruction order.
//   res.valid rises once the instruction has passed an input register and
//   then decode/shift/ALU logic into the result register; a res stall can
//   hold it in either register before the res transfer.
//   Throughput is one instruction per cycle while res does not stall. The
//   flags register is updated as an instruction moves into the result
//   register, so the next instruction sees its carry without a bubble.
//   When res stalls, the result register holds and the input register still
//   takes one more instruction; cmd.ready drops only once both are full.
//   Reset (rst, synchronous) clears both stages and the flags to zero.
//   Unsupported op codes or a mismatched encoding give handled low with
//   zero outputs and the flags unchanged.
// ----------------------------------------------------------------------------
module thumb2_data_processing_unit (
  input  logic        clk,
  input  logic        rst,
  t2dpu_in_if.sink    cmd,
  t2dpu_out_if.source res
);

  // input register
  logic        s1_valid;
  logic [15:0] s1_first;
  logic [15:0] s1_second;
  logic [31:0] s1_rn;
  logic [31:0] s1_rm;
  logic        s1_form;

  // result register
  logic             out_valid;
  logic             out_handled;
  logic [31:0]      out_value;
  logic [3:0]       out_dest;
  logic             out_wreg;
  logic             out_wpc;
  t2dpu_pkg::nzcv_t out_flags;

  t2dpu_pkg::nzcv_t flags;
  t2dpu_pkg::nzcv_t flags_next;

  logic s1_adv;
  logic in_take;

  assign s1_adv  = s1_valid && (!out_valid || res.ready);
  assign in_take = cmd.valid && cmd.ready;
  assign cmd.ready = !s1_valid || s1_adv;

  // ---------------- decode ----------------
  logic [3:0]  op_code;
  logic        s_bit;
  logic [3:0]  rd;
  logic        cflag;
  logic        match;

  assign op_code = s1_first[8:5];
  assign s_bit   = s1_first[4];
  assign rd      = s1_second[11:8];
  assign cflag   = flags[t2dpu_pkg::FLAG_C];

  always_comb begin
    if (s1_form) begin
      match = ((s1_first & t2dpu_pkg::REG_CLASS_MASK) == t2dpu_pkg::REG_CLASS_CODE)
              && !s1_second[15];
    end else begin
      match = ((s1_first & t2dpu_pkg::IMM_CLASS_MASK) == t2dpu_pkg::IMM_CLASS_CODE)
              && !s1_second[15];
    end
  end

  // ---------------- modified immediate ----------------
  logic [11:0] imm12;
  logic [7:0]  imm_byte;
  logic [31:0] imm_value;
  logic        imm_carry;
  logic [31:0] rot_base;
  logic [63:0] rot_wide;

  assign imm12    = {s1_first[10], s1_second[14:12], s1_second[7:0]};
  assign imm_byte = imm12[7:0];
  assign rot_base = {24'd0, 1'b1, imm12[6:0]};
  assign rot_wide = {rot_base, rot_base} >> imm12[11:7];

  always_comb begin
    imm_value = rot_wide[31:0];
    imm_carry = rot_wide[31];
    if (imm12[11:10] == 2'd0) begin
      imm_carry = cflag;
      case (t2dpu_pkg::rep_t'(imm12[9:8]))
        t2dpu_pkg::REP_PLAIN: imm_value = {24'd0, imm_byte};
        t2dpu_pkg::REP_ODD:   imm_value = {8'd0, imm_byte, 8'd0, imm_byte};
        t2dpu_pkg::REP_EVEN:  imm_value = {imm_byte, 8'd0, imm_byte, 8'd0};
        t2dpu_pkg::REP_ALL:   imm_value = {imm_byte, imm_byte, imm_byte, imm_byte};
        default:              imm_value = {24'd0, imm_byte};
      endcase
    end
  end

  // ---------------- immediate shift ----------------
  logic [4:0]  sh_amt;
  logic [32:0] lsl_wide;
  logic [32:0] lsr_wide;
  logic [32:0] asr_wide;
  logic [63:0] ror_wide;
  logic [31:0] sh_value;
  logic        sh_carry;

  assign sh_amt   = {s1_second[14:12], s1_second[7:6]};
  assign lsl_wide = {1'b0, s1_rm} << sh_amt;
  assign lsr_wide = {s1_rm, 1'b0} >> sh_amt;
  assign asr_wide = 33'($signed({s1_rm, 1'b0}) >>> sh_amt);
  assign ror_wide = {s1_rm, s1_rm} >> sh_amt;

  always_comb begin
    sh_value = s1_rm;
    sh_carry = cflag;
    case (t2dpu_pkg::shift_t'(s1_second[5:4]))
      t2dpu_pkg::SH_LSL: begin
        if (sh_amt != 5'd0) begin
          sh_value = lsl_wide[31:0];
          sh_carry = lsl_wide[32];
        end
      end
      t2dpu_pkg::SH_LSR: begin
        // amount zero encodes a shift by 32
        if (sh_amt == 5'd0) begin
          sh_value = 32'd0;
          sh_carry = s1_rm[31];
        end else begin
          sh_value = lsr_wide[32:1];
          sh_carry = lsr_wide[0];
        end
      end
      t2dpu_pkg::SH_ASR: begin
        if (sh_amt == 5'd0) begin
          sh_value = {32{s1_rm[31]}};
          sh_carry = s1_rm[31];
        end else begin
          sh_value = asr_wide[32:1];
          sh_carry = asr_wide[0];
        end
      end
      t2dpu_pkg::SH_ROR: begin
        // amount zero is RRX through the carry
        if (sh_amt == 5'd0) begin
          sh_value = {cflag, s1_rm[31:1]};
          sh_carry = s1_rm[0];
        end else begin
          sh_value = ror_wide[31:0];
          sh_carry = ror_wide[31];
        end
      end
      default: begin
        sh_value = s1_rm;
        sh_carry = cflag;
      end
    endcase
  end

  // ---------------- ALU ----------------
  logic [31:0] left;
  logic [31:0] right;
  logic        logic_carry;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] add_sum;
  logic        add_ov;
  logic [31:0] alu_value;
  logic        arith;
  logic        op_ok;
  logic        handled;

  assign left        = (s1_first[3:0] == t2dpu_pkg::REG_PC) ? 32'd0 : s1_rn;
  assign right       = s1_form ? sh_value : imm_value;
  assign logic_carry = s1_form ? sh_carry : imm_carry;

  always_comb begin
    add_a     = left;
    add_b     = right;
    add_cin   = 1'b0;
    arith     = 1'b0;
    op_ok     = 1'b1;
    alu_value = 32'd0;
    case (t2dpu_pkg::op_t'(op_code))
      t2dpu_pkg::OP_AND: alu_value = left & right;
      t2dpu_pkg::OP_BIC: alu_value = left & ~right;
      t2dpu_pkg::OP_ORR: alu_value = left | right;
      t2dpu_pkg::OP_ORN: alu_value = left | ~right;
      t2dpu_pkg::OP_EOR: alu_value = left ^ right;
      t2dpu_pkg::OP_ADD: arith = 1'b1;
      t2dpu_pkg::OP_ADC: begin
        arith   = 1'b1;
        add_cin = cflag;
      end
      t2dpu_pkg::OP_SBC: begin
        arith   = 1'b1;
        add_b   = ~right;
        add_cin = cflag;
      end
      t2dpu_pkg::OP_SUB: begin
        arith   = 1'b1;
        add_b   = ~right;
        add_cin = 1'b1;
      end
      t2dpu_pkg::OP_RSB: begin
        arith   = 1'b1;
        add_a   = ~left;
        add_cin = 1'b1;
      end
      default: op_ok = 1'b0;
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_ov  = (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ add_sum[31]);

  logic [31:0] op_value;
  assign op_value = arith ? add_sum[31:0] : alu_value;
  assign handled  = match && op_ok;

  always_comb begin
    flags_next = flags;
    if (handled && s_bit) begin
      flags_next[t2dpu_pkg::FLAG_N] = op_value[31];
      flags_next[t2dpu_pkg::FLAG_Z] = (op_value == 32'd0);
      if (arith) begin
        flags_next[t2dpu_pkg::FLAG_C] = add_sum[32];
        flags_next[t2dpu_pkg::FLAG_V] = add_ov;
      end else begin
        flags_next[t2dpu_pkg::FLAG_C] = logic_carry;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        flags     <= flags_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_first  <= cmd.first_half;
      s1_second <= cmd.second_half;
      s1_rn     <= cmd.rn_value;
      s1_rm     <= cmd.rm_value;
      s1_form   <= cmd.register_form;
    end
    if (s1_adv) begin
      out_handled <= handled;
      out_value   <= handled ? op_value : 32'd0;
      out_dest    <= handled ? rd : 4'd0;
      out_wreg    <= handled && (rd != t2dpu_pkg::REG_PC);
      out_wpc     <= handled && (rd == t2dpu_pkg::REG_PC) && !s_bit;
      out_flags   <= flags_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.handled      = out_handled;
  assign res.result_value = out_value;
  assign res.dest_index   = out_dest;
  assign res.write_reg    = out_wreg;
  assign res.write_pc     = out_wpc;
  assign res.flags_out    = out_flags;

`ifndef SYNTH
  // the flags move only when an instruction enters the result register
  assert property (@(posedge clk) disable iff (rst) !s1_adv |=> $stable(flags))
    else $error("flags changed without an instruction completing");

  // a waiting result always carries the current flags
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_flags == flags))
    else $error("result flags differ from flag register");

  // an unhandled instruction writes nothing
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_handled) |-> (!out_wreg && !out_wpc && (out_value == 32'd0)))
    else $error("unhandled instruction produced a write");

  // register and PC writes exclude each other
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_wreg && out_wpc))
    else $error("register and PC write both set");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Thumb-2 data-processing unit
// Sends modified-immediate and shifted-register instructions through the
// command channel and checks every result against an in-order prediction
// that tracks the NZCV flags. A directed set of edge cases comes first, then
// random instructions under three idle patterns and long result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import t2dpu_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 630;
  localparam int unsigned HOLD_CYCLES      = 60;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned MAX_REPORTS      = 40;
  localparam logic [3:0]  OP_UNDEF         = 4'd5;

  typedef struct packed {
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic        register_form;
  } dpu_instr_t;

  typedef struct packed {
    logic        handled;
    logic [31:0] result_value;
    logic [3:0]  dest_index;
    logic        write_reg;
    logic        write_pc;
    nzcv_t       flags_out;
  } dpu_result_t;

  function automatic bit op_known(logic [3:0] op);
    case (op)
      OP_AND, OP_BIC, OP_ORR, OP_ORN, OP_EOR,
      OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  class dpu_scoreboard;
    nzcv_t       flags;
    dpu_result_t pending_results[$];
    int unsigned error_count;

    function new();
      flags = '0;
      error_count = 0;
    endfunction

    function logic [31:0] ror_word(logic [31:0] v, logic [4:0] n);
      logic [63:0] d;
      d = {v, v} >> n;
      return d[31:0];
    endfunction

    function logic [31:0] expand_imm(logic [11:0] imm12, logic cin, output logic cout);
      logic [7:0]  b;
      logic [31:0] v;
      b = imm12[7:0];
      if (imm12[11:10] == 2'b00) begin
        case (rep_t'(imm12[9:8]))
          REP_PLAIN: v = {24'b0, b};
          REP_ODD:   v = {8'b0, b, 8'b0, b};
          REP_EVEN:  v = {b, 8'b0, b, 8'b0};
          default:   v = {4{b}};
        endcase
        cout = cin;
      end else begin
        v = ror_word({24'b0, 1'b1, imm12[6:0]}, imm12[11:7]);
        cout = v[31];
      end
      return v;
    endfunction

    // zero amounts: LSL passes carry, LSR/ASR shift by 32, ROR is RRX
    function logic [31:0] shift_operand(logic [31:0] v, shift_t kind, logic [4:0] amt,
                                        logic cin, output logic cout);
      logic [32:0] wide;
      logic [31:0] r;
      case (kind)
        SH_LSL: begin
          if (amt == 0) begin
            cout = cin;
            r = v;
          end else begin
            wide = {1'b0, v} << amt;
            cout = wide[32];
            r = wide[31:0];
          end
        end
        SH_LSR: begin
          if (amt == 0) begin
            cout = v[31];
            r = '0;
          end else begin
            cout = v[amt - 1];
            r = v >> amt;
          end
        end
        SH_ASR: begin
          if (amt == 0) begin
            cout = v[31];
            r = {32{v[31]}};
          end else begin
            cout = v[amt - 1];
            r = $signed(v) >>> amt;
          end
        end
        default: begin
          if (amt == 0) begin
            cout = v[0];
            r = {cin, v[31:1]};
          end else begin
            r = ror_word(v, amt);
            cout = r[31];
          end
        end
      endcase
      return r;
    endfunction

    function logic [31:0] add_with_carry(logic [31:0] a, logic [31:0] b, logic cin,
                                         output logic cout, output logic ovf);
      logic [32:0] t;
      t = {1'b0, a} + {1'b0, b} + {32'b0, cin};
      cout = t[32];
      ovf = ~(a[31] ^ b[31]) & (a[31] ^ t[31]);
      return t[31:0];
    endfunction

    function void note_instr(dpu_instr_t it);
      logic [3:0]  op;
      logic [3:0]  rd;
      logic        s, old_c, op_carry, add_carry, add_ovf, arith, fits;
      logic [31:0] lhs, rhs, sum;
      dpu_result_t want;
      op = it.first_half[8:5];
      s = it.first_half[4];
      rd = it.second_half[11:8];
      old_c = flags[FLAG_C];
      arith = 1'b0;
      add_carry = 1'b0;
      add_ovf = 1'b0;
      sum = '0;
      if (it.register_form) begin
        fits = ((it.first_half & REG_CLASS_MASK) == REG_CLASS_CODE) && !it.second_half[15];
        rhs = shift_operand(it.rm_value, shift_t'(it.second_half[5:4]),
                            {it.second_half[14:12], it.second_half[7:6]}, old_c, op_carry);
      end else begin
        fits = ((it.first_half & IMM_CLASS_MASK) == IMM_CLASS_CODE) && !it.second_half[15];
        rhs = expand_imm({it.first_half[10], it.second_half[14:12], it.second_half[7:0]},
                         old_c, op_carry);
      end
      lhs = (it.first_half[3:0] == REG_PC) ? '0 : it.rn_value;
      case (op)
        OP_AND: sum = lhs & rhs;
        OP_BIC: sum = lhs & ~rhs;
        OP_ORR: sum = lhs | rhs;
        OP_ORN: sum = lhs | ~rhs;
        OP_EOR: sum = lhs ^ rhs;
        OP_ADD: begin
          arith = 1'b1;
          sum = add_with_carry(lhs, rhs, 1'b0, add_carry, add_ovf);
        end
        OP_ADC: begin
          arith = 1'b1;
          sum = add_with_carry(lhs, rhs, old_c, add_carry, add_ovf);
        end
        OP_SBC: begin
          arith = 1'b1;
          sum = add_with_carry(lhs, ~rhs, old_c, add_carry, add_ovf);
        end
        OP_SUB: begin
          arith = 1'b1;
          sum = add_with_carry(lhs, ~rhs, 1'b1, add_carry, add_ovf);
        end
        OP_RSB: begin
          arith = 1'b1;
          sum = add_with_carry(~lhs, rhs, 1'b1, add_carry, add_ovf);
        end
        default: ;
      endcase
      want = '0;
      if (fits && op_known(op)) begin
        if (s) begin
          flags[FLAG_N] = sum[31];
          flags[FLAG_Z] = (sum == 0);
          flags[FLAG_C] = arith ? add_carry : op_carry;
          if (arith) flags[FLAG_V] = add_ovf;
        end
        want.handled = 1'b1;
        want.result_value = sum;
        want.dest_index = rd;
        want.write_reg = (rd != REG_PC);
        want.write_pc = (rd == REG_PC) && !s;
      end
      want.flags_out = flags;
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("[%0t] %s: got %h expected %h", $time, field, got, want);
    endtask

    task check_result(dpu_result_t got);
      dpu_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got.result_value, '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.handled !== want.handled)
        report_mismatch("handled", 32'(got.handled), 32'(want.handled));
      if (got.result_value !== want.result_value)
        report_mismatch("result_value", got.result_value, want.result_value);
      if (got.dest_index !== want.dest_index)
        report_mismatch("dest_index", 32'(got.dest_index), 32'(want.dest_index));
      if (got.write_reg !== want.write_reg)
        report_mismatch("write_reg", 32'(got.write_reg), 32'(want.write_reg));
      if (got.write_pc !== want.write_pc)
        report_mismatch("write_pc", 32'(got.write_pc), 32'(want.write_pc));
      if (got.flags_out !== want.flags_out)
        report_mismatch("flags_out", 32'(got.flags_out), 32'(want.flags_out));
    endtask
  endclass

  logic clk;
  logic rst;
  t2dpu_in_if  cmd_if ();
  t2dpu_out_if res_if ();

  dpu_scoreboard tracker;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  bit            hold_request;
  int unsigned   hold_left;

  thumb2_data_processing_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #6 clk = ~clk;

  function automatic dpu_instr_t imm_instr(logic [3:0] op, logic s, logic [3:0] rn,
                                           logic [3:0] rd, logic [11:0] imm12,
                                           logic [31:0] rn_val);
    dpu_instr_t it;
    it.first_half = IMM_CLASS_CODE | {5'b0, imm12[11], 1'b0, op, s, rn};
    it.second_half = {1'b0, imm12[10:8], rd, imm12[7:0]};
    it.rn_value = rn_val;
    it.rm_value = $urandom;
    it.register_form = 1'b0;
    return it;
  endfunction

  function automatic dpu_instr_t reg_instr(logic [3:0] op, logic s, logic [3:0] rn,
                                           logic [3:0] rd, shift_t kind, logic [4:0] amt,
                                           logic [31:0] rn_val, logic [31:0] rm_val);
    dpu_instr_t it;
    logic [3:0] rm;
    rm = 4'($urandom_range(15));
    it.first_half = REG_CLASS_CODE | {7'b0, op, s, rn};
    it.second_half = {1'b0, amt[4:2], rd, amt[1:0], kind, rm};
    it.rn_value = rn_val;
    it.rm_value = rm_val;
    it.register_form = 1'b1;
    return it;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed; some broken encodings and a little pure noise
  function automatic dpu_instr_t random_instr();
    dpu_instr_t  it;
    logic [3:0]  op, rd;
    logic [4:0]  amt;
    logic [11:0] imm12;
    int          kind;
    kind = $urandom_range(99);
    if (kind >= 95) begin
      it.first_half = 16'($urandom);
      it.second_half = 16'($urandom);
      it.rn_value = $urandom;
      it.rm_value = $urandom;
      it.register_form = 1'($urandom_range(1));
      return it;
    end
    op = 4'($urandom_range(15));
    if ($urandom_range(99) < 85)
      while (!op_known(op)) op = 4'($urandom_range(15));
    rd = ($urandom_range(7) == 0) ? REG_PC : 4'($urandom_range(15));
    if ($urandom_range(1)) begin
      amt = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
      it = reg_instr(op, 1'($urandom_range(1)), 4'($urandom_range(15)), rd,
                     shift_t'($urandom_range(3)), amt, pick_word(), pick_word());
    end else begin
      imm12 = 12'($urandom);
      if ($urandom_range(5) == 0) imm12[7:0] = '0;
      it = imm_instr(op, 1'($urandom_range(1)), 4'($urandom_range(15)), rd, imm12,
                     pick_word());
    end
    if (kind >= 87) begin
      case ($urandom_range(2))
        0: it.second_half[15] = 1'b1;
        1: it.first_half[$urandom_range(15, 9)] = ~it.first_half[$urandom_range(15, 9)];
        default: it.register_form = ~it.register_form;
      endcase
    end
    return it;
  endfunction

  task send_instr(dpu_instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.first_half <= it.first_half;
    cmd_if.second_half <= it.second_half;
    cmd_if.rn_value <= it.rn_value;
    cmd_if.rm_value <= it.rm_value;
    cmd_if.register_form <= it.register_form;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    tracker.note_instr(it);
  endtask

  task run_directed();
    dpu_instr_t it;
    send_instr(imm_instr(OP_AND, 1'b1, 4'd1, 4'd2, 12'h0ff, 32'hffff_ffff));
    send_instr(imm_instr(OP_ORR, 1'b1, 4'd1, 4'd2, 12'h1a5, 32'h0000_0000));
    send_instr(imm_instr(OP_EOR, 1'b1, 4'd3, 4'd4, 12'h2ff, 32'hffff_ffff));
    send_instr(imm_instr(OP_ADD, 1'b1, 4'd3, 4'd4, 12'h3ff, 32'h0000_0001));
    // replicated zero byte
    send_instr(imm_instr(OP_ORR, 1'b1, 4'd5, 4'd6, 12'h300, 32'h0000_0000));
    send_instr(imm_instr(OP_ORR, 1'b1, 4'd5, 4'd6, 12'h100, 32'h0000_0000));
    // rotated immediates, carry from bit 31
    send_instr(imm_instr(OP_AND, 1'b1, 4'd7, 4'd8, 12'h4ff, 32'hffff_ffff));
    send_instr(imm_instr(OP_BIC, 1'b1, 4'd7, 4'd8, 12'hfff, 32'hffff_ffff));
    send_instr(imm_instr(OP_ADD, 1'b1, 4'd0, 4'd1, 12'h001, 32'h7fff_ffff));
    send_instr(imm_instr(OP_ADC, 1'b1, 4'd0, 4'd1, 12'h000, 32'hffff_ffff));
    send_instr(imm_instr(OP_SBC, 1'b1, 4'd0, 4'd1, 12'h000, 32'h0000_0000));
    send_instr(imm_instr(OP_SUB, 1'b1, 4'd0, 4'd1, 12'h001, 32'h8000_0000));
    send_instr(imm_instr(OP_RSB, 1'b1, 4'd0, 4'd1, 12'h000, 32'h0000_0000));
    send_instr(imm_instr(OP_ORN, 1'b0, 4'd0, 4'd1, 12'h000, 32'h0000_0000));
    // Rn of PC reads as zero
    send_instr(imm_instr(OP_ADD, 1'b0, REG_PC, 4'd1, 12'h005, 32'h1234_5678));
    // compare (no write), then PC write
    send_instr(imm_instr(OP_SUB, 1'b1, 4'd2, REG_PC, 12'h005, 32'h0000_0005));
    send_instr(imm_instr(OP_ADD, 1'b0, 4'd2, REG_PC, 12'h010, 32'h0000_1000));
    send_instr(reg_instr(OP_ORR, 1'b1, 4'd3, 4'd9, SH_LSL, 5'd0, 32'h0, 32'h0000_0000));
    send_instr(reg_instr(OP_ORR, 1'b1, REG_PC, 4'd9, SH_LSR, 5'd0, 32'h0, 32'h8000_0000));
    send_instr(reg_instr(OP_ORR, 1'b1, REG_PC, 4'd9, SH_ASR, 5'd0, 32'h0, 32'h8000_0000));
    send_instr(reg_instr(OP_EOR, 1'b1, 4'd3, 4'd9, SH_ROR, 5'd0, 32'h0, 32'h0000_0001));
    send_instr(reg_instr(OP_ADD, 1'b1, 4'd3, 4'd9, SH_LSL, 5'd31, 32'h8000_0000, 32'h3));
    send_instr(reg_instr(OP_SUB, 1'b1, 4'd3, 4'd9, SH_ASR, 5'd7, 32'h1, 32'h8000_0080));
    send_instr(imm_instr(OP_UNDEF, 1'b1, 4'd1, 4'd2, 12'h0ff, 32'hffff_ffff));
    // wrong encoding class for the chosen form, then bit 15 of the second half set
    it = imm_instr(OP_ADD, 1'b1, 4'd1, 4'd2, 12'h0ff, 32'h1);
    it.register_form = 1'b1;
    send_instr(it);
    it = reg_instr(OP_ADD, 1'b1, 4'd1, 4'd2, SH_ROR, 5'd8, 32'h1, 32'h1);
    it.second_half[15] = 1'b1;
    send_instr(it);
  endtask

  // result side: check at each transfer, random stalls and long hold-offs
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready)
        tracker.check_result({res_if.handled, res_if.result_value, res_if.dest_index,
                              res_if.write_reg, res_if.write_pc, res_if.flags_out});
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("thumb2_data_processing_unit: mismatch");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.first_half = '0;
    cmd_if.second_half = '0;
    cmd_if.rn_value = '0;
    cmd_if.rm_value = '0;
    cmd_if.register_form = 1'b0;
    res_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // receiver holds off while directed items keep coming: input must stall
    hold_request = 1'b1;
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
      hold_request = 1'b1;
      repeat (RANDOM_PER_PHASE) send_instr(random_instr());
    end
    cmd_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count == 0)
      $display("thumb2_data_processing_unit: match");
    else
      $display("thumb2_data_processing_unit: mismatch");
    $finish;
  end

endmodule

@@ thumb2_data_processing_unit.f @@
hdl/t2dpu_pkg.sv
hdl/t2dpu_in_if.sv
hdl/t2dpu_out_if.sv
hdl/thumb2_data_processing_unit.sv
test/tb_top.sv
